// ===== rtl/adrc_pkg.sv =====
// Package with the shared types and constants of the audio dynamic range compressor.
`timescale 1ns / 1ps

package adrc_pkg;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 15;
  localparam int GAIN_W   = 4;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 4;

  // Gain reductions above this value clip the output to the threshold.
  localparam logic [GAIN_W-1:0] HARD_LIMIT_SHIFT = GAIN_W'(4);

  // Largest envelope level.
  localparam logic [LEVEL_W-1:0] ENV_MAX = {LEVEL_W{1'b1}};

  // Register reset values.
  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = LEVEL_W'(32767);
  localparam logic [GAIN_W-1:0]  GAIN_RST      = GAIN_W'(0);
  localparam logic [LEVEL_W-1:0] ATTACK_RST    = LEVEL_W'(1000);
  localparam logic [LEVEL_W-1:0] RELEASE_RST   = LEVEL_W'(100);

  // Register indexes; register i sits at byte address 4*i.
  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_GAIN      = 2'd1,
    REG_ATTACK    = 2'd2,
    REG_RELEASE   = 2'd3
  } reg_idx_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [LEVEL_W-1:0] threshold;
    logic [GAIN_W-1:0]  gain_reduction;
    logic [LEVEL_W-1:0] attack_step;
    logic [LEVEL_W-1:0] release_step;
  } cfg_t;

endpackage

// ===== rtl/adrc_regs.sv =====
// APB configuration register file of the audio dynamic range compressor.
`timescale 1ns / 1ps

module adrc_regs
  import adrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes on the access phase of a write transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold      <= THRESHOLD_RST;
      cfg.gain_reduction <= GAIN_RST;
      cfg.attack_step    <= ATTACK_RST;
      cfg.release_step   <= RELEASE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_THRESHOLD: cfg.threshold      <= pwdata[LEVEL_W-1:0];
        REG_GAIN:      cfg.gain_reduction <= pwdata[GAIN_W-1:0];
        REG_ATTACK:    cfg.attack_step    <= pwdata[LEVEL_W-1:0];
        REG_RELEASE:   cfg.release_step   <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = APB_DW'(cfg.threshold);
      REG_GAIN:      prdata = APB_DW'(cfg.gain_reduction);
      REG_ATTACK:    prdata = APB_DW'(cfg.attack_step);
      REG_RELEASE:   prdata = APB_DW'(cfg.release_step);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/audio_dynamic_range_compressor.sv =====
// Top level of the audio dynamic range compressor: input register, shaper, envelope, output.
`timescale 1ns / 1ps

// Each accepted sample produces exactly one output sample. A sample is caught in an
// input register and is then shaped against the current envelope and written to the
// output register while the envelope is updated; a new sample can be taken every
// cycle while the output side keeps up. While the output is stalled the input
// register still takes one sample if it is empty, then holds. Registers (APB,
// 4 bytes apart): threshold at 0x0, gain_reduction at 0x4, attack_step at 0x8,
// release_step at 0xC; write them only while no samples are in flight.
module audio_dynamic_range_compressor
  import adrc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_AW-1:0]          paddr,
  input  logic [APB_DW-1:0]          pwdata,
  output logic [APB_DW-1:0]          prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  cfg_t cfg;

  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic [LEVEL_W-1:0]         envelope;
  logic [LEVEL_W-1:0]         envelope_next;
  logic                       advance;
  logic                       fire;

  logic signed [17:0]         s_ext;
  logic signed [17:0]         t_ext;
  logic signed [17:0]         knee_dist;
  logic signed [17:0]         knee;
  logic signed [17:0]         shifted;
  logic signed [17:0]         y_full;
  logic signed [SAMPLE_W-1:0] y;
  logic                       positive;
  logic [15:0]                mag;
  logic [15:0]                env_ext;
  logic [15:0]                diff;
  logic [15:0]                rise;

  adrc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline flow control: both stages move when the output register is free.
  assign advance  = !out_valid || out_ready;
  assign fire     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample <= sample_in;
    end
  end

  // Shaper: pass while envelope < threshold, else hard limit or compress toward knee.
  always_comb begin
    s_ext     = {{2{s1_sample[SAMPLE_W-1]}}, s1_sample};
    t_ext     = {3'b000, cfg.threshold};
    positive  = !s1_sample[SAMPLE_W-1] && (s1_sample != '0);
    knee      = positive ? t_ext : -t_ext;
    knee_dist = s_ext - knee;
    shifted   = knee_dist >>> cfg.gain_reduction[2:0];
    if (envelope < cfg.threshold) begin
      y_full = s_ext;
    end else if (cfg.gain_reduction > HARD_LIMIT_SHIFT) begin
      y_full = t_ext;
    end else begin
      y_full = knee + shifted;
    end
    y = y_full[SAMPLE_W-1:0];
  end

  // Envelope follower with separate rise and fall limits.
  always_comb begin
    mag     = y[SAMPLE_W-1] ? 16'(-y) : 16'(y);
    env_ext = {1'b0, envelope};
    rise    = '0;
    if (mag < env_ext) begin
      diff = env_ext - mag;
      if (diff > {1'b0, cfg.release_step}) begin
        envelope_next = envelope - cfg.release_step;
      end else begin
        envelope_next = mag[LEVEL_W-1:0];
      end
    end else begin
      diff = mag - env_ext;
      if (diff > {1'b0, cfg.attack_step}) begin
        rise = env_ext + {1'b0, cfg.attack_step};
      end else begin
        rise = mag;
      end
      envelope_next = (rise > {1'b0, ENV_MAX}) ? ENV_MAX : rise[LEVEL_W-1:0];
    end
  end

  // Envelope and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      envelope  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        envelope <= envelope_next;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (fire) begin
      sample_out <= y;
    end
  end

  // The envelope only moves when a sample is passed to the output register.
  a_env_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(envelope))
    else $error("envelope changed without a sample transfer");

  // The envelope never rises by more than attack_step.
  a_env_attack: assert property (@(posedge clk) disable iff (rst)
    fire |=> ({1'b0, envelope} <= {1'b0, $past(envelope)} + {1'b0, $past(cfg.attack_step)}))
    else $error("envelope rose faster than attack_step");

  // The envelope never falls by more than release_step.
  a_env_release: assert property (@(posedge clk) disable iff (rst)
    fire |=> ({1'b0, envelope} + {1'b0, $past(cfg.release_step)} >= {1'b0, $past(envelope)}))
    else $error("envelope fell faster than release_step");

  // Input is refused only when both stages are full and the output is stalled.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input refused while the pipeline could move");

  // A shaped sample shows up at the output on the next cycle.
  a_out_follow: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("shaped sample lost on its way to the output");

endmodule

// ===== bench/tb_audio_dynamic_range_compressor.sv =====
// Self-checking testbench for the audio dynamic range compressor.
`timescale 1ns / 1ps

module tb_audio_dynamic_range_compressor;
  import adrc_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_CYCLES     = 60;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_REPORTS     = 10;

  // Kinds of row in the directed table.
  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    reg_idx_t                   idx;
    logic [APB_DW-1:0]          wdata;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       known;
    logic signed [SAMPLE_W-1:0] known_out;
  } dir_row_t;

  localparam int NUM_ROWS = 37;

  // Directed rows: full-scale values, the hard limit, shifts of the excess,
  // samples inside the knee, a frozen envelope and a return to reset values.
  dir_row_t directed_rows [0:NUM_ROWS-1] = '{
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sd0, 1'b1, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sd32767, 1'b1, 16'sd32767},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sh8000, 1'b1, 16'sh8000},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, -16'sd1, 1'b1, -16'sd1},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sd1, 1'b1, 16'sd1},
    '{ROW_WRITE, REG_THRESHOLD, 32'd0, 16'sd0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_GAIN, 32'd5, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sh8000, 1'b1, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sd12345, 1'b1, 16'sd0},
    '{ROW_WRITE, REG_GAIN, 32'd1, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sd32767, 1'b1, 16'sd16383},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sh8000, 1'b1, 16'shC000},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, -16'sd1, 1'b1, -16'sd1},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sd0, 1'b1, 16'sd0},
    '{ROW_WRITE, REG_THRESHOLD, 32'd1000, 16'sd0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_GAIN, 32'd4, 16'sd0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_ATTACK, 32'd32767, 16'sd0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_RELEASE, 32'd32767, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sd30000, 1'b0, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sd500, 1'b0, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, -16'sd500, 1'b0, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sh8000, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_THRESHOLD, 32'd20000, 16'sd0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_GAIN, 32'd15, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, -16'sd30000, 1'b0, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sd100, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_ATTACK, 32'd0, 16'sd0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_RELEASE, 32'd0, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sd32767, 1'b0, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, -16'sd5, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_THRESHOLD, 32'd32767, 16'sd0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_GAIN, 32'd0, 16'sd0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_ATTACK, 32'd1000, 16'sd0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_RELEASE, 32'd100, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sd32767, 1'b0, 16'sd0},
    '{ROW_SAMPLE, REG_THRESHOLD, 32'd0, 16'sh8000, 1'b0, 16'sd0}
  };

  logic                       clk;
  logic                       rst;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [APB_AW-1:0]          paddr;
  logic [APB_DW-1:0]          pwdata;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  // Copy of the configuration and envelope kept alongside the block.
  cfg_t               model_cfg;
  logic [LEVEL_W-1:0] model_level;

  logic signed [SAMPLE_W-1:0] expected_out[$];

  bit idle_on;
  bit hold_req;
  int cycle_count;
  int mismatches;
  int samples_sent;
  int outputs_checked;
  int settings_written;

  audio_dynamic_range_compressor uut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Shape one sample against the envelope, then slew the envelope toward
  // the magnitude of the output.
  function automatic logic signed [SAMPLE_W-1:0] compress_step(
    input logic signed [SAMPLE_W-1:0] s
  );
    int x;
    int knee;
    int y;
    int mag;
    int lvl;
    int delta;
    x    = s;
    knee = model_cfg.threshold;
    lvl  = model_level;
    if (lvl < knee) begin
      y = x;
    end else if (model_cfg.gain_reduction > HARD_LIMIT_SHIFT) begin
      y = knee;
    end else if (x > 0) begin
      y = knee + ((x - knee) >>> model_cfg.gain_reduction);
    end else begin
      y = -knee + ((x + knee) >>> model_cfg.gain_reduction);
    end
    mag   = (y < 0) ? -y : y;
    delta = mag - lvl;
    if (delta < 0) begin
      if (-delta > int'(model_cfg.release_step)) lvl -= int'(model_cfg.release_step);
      else lvl = mag;
      if (lvl < 0) lvl = 0;
    end else begin
      if (delta > int'(model_cfg.attack_step)) lvl += int'(model_cfg.attack_step);
      else lvl = mag;
      if (lvl > int'(ENV_MAX)) lvl = int'(ENV_MAX);
    end
    model_level = LEVEL_W'(lvl);
    return SAMPLE_W'(y);
  endfunction

  // Random sample: mostly full range, some near the knee, some corner values (full-scale, zero, plus or minus one).
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int kind;
    int v;
    kind = $urandom_range(9);
    if (kind == 0) begin
      case ($urandom_range(4))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        3: v = -1;
        default: v = 1;
      endcase
    end else if (kind <= 3) begin
      v = int'(model_cfg.threshold) + int'($urandom_range(64)) - 32;
      if ($urandom_range(1) == 1) v = -v;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end else begin
      v = int'($signed(SAMPLE_W'($urandom)));
    end
    return SAMPLE_W'(v);
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("Mismatch on %s at cycle %0d: expected %0d, got %0d",
               what, cycle_count, want, got);
    end
  endtask

  // Offer one sample and hold it until the input transfer completes.
  task automatic offer_sample(
    input logic signed [SAMPLE_W-1:0] s,
    input logic                       known,
    input logic signed [SAMPLE_W-1:0] known_out
  );
    logic signed [SAMPLE_W-1:0] predicted;
    if (idle_on) begin
      while ($urandom_range(99) < 33) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_valid  = 1'b1;
    sample_in = s;
    do @(posedge clk); while (!in_ready);
    predicted = compress_step(s);
    expected_out.push_back(known ? known_out : predicted);
    samples_sent++;
  endtask

  // Stop offering and wait for every pending output to drain.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_out.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // Write a register over APB, then read it back.
  task automatic write_register(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] stored;
    stored = (idx == REG_GAIN) ? (value & 32'hF) : (value & 32'h7FFF);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_THRESHOLD: model_cfg.threshold      = LEVEL_W'(stored);
      REG_GAIN:      model_cfg.gain_reduction = GAIN_W'(stored);
      REG_ATTACK:    model_cfg.attack_step    = LEVEL_W'(stored);
      REG_RELEASE:   model_cfg.release_step   = LEVEL_W'(stored);
      default: ;
    endcase
    settings_written++;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) report_mismatch("register read", int'(stored), int'(prdata));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready = !(idle_on && ($urandom_range(99) < 33));
      end
    end
  end

  // Compare each output transfer with the oldest pending prediction.
  always @(posedge clk) begin : check_outputs
    logic signed [SAMPLE_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        report_mismatch("unexpected sample_out", 0, int'(sample_out));
      end else begin
        want = expected_out.pop_front();
        outputs_checked++;
        if (sample_out !== want) report_mismatch("sample_out", int'(want), int'(sample_out));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d outputs pending",
               cycle_count, expected_out.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    sample_in = '0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    model_cfg.threshold      = THRESHOLD_RST;
    model_cfg.gain_reduction = GAIN_RST;
    model_cfg.attack_step    = ATTACK_RST;
    model_cfg.release_step   = RELEASE_RST;
    model_level              = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table.
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        settle();
        write_register(directed_rows[r].idx, directed_rows[r].wdata);
      end else begin
        offer_sample(directed_rows[r].sample, directed_rows[r].known,
                     directed_rows[r].known_out);
      end
    end

    // Random phases, each under a fresh register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      idle_on = (p != 0);
      case ($urandom_range(4))
        0: write_register(REG_THRESHOLD, 32'd0);
        1: write_register(REG_THRESHOLD, 32'd32767);
        2: write_register(REG_THRESHOLD, $urandom_range(32767));
        default: write_register(REG_THRESHOLD, $urandom_range(16000, 2000));
      endcase
      if (p == 1) write_register(REG_GAIN, 32'd15);
      else if (p == 2) write_register(REG_GAIN, 32'd0);
      else write_register(REG_GAIN, ($urandom_range(3) == 0) ? $urandom_range(15)
                                                             : $urandom_range(4));
      case ($urandom_range(3))
        0: write_register(REG_ATTACK, 32'd0);
        1: write_register(REG_ATTACK, 32'd32767);
        default: write_register(REG_ATTACK, $urandom_range(4000));
      endcase
      case ($urandom_range(3))
        0: write_register(REG_RELEASE, 32'd0);
        1: write_register(REG_RELEASE, 32'd32767);
        default: write_register(REG_RELEASE, $urandom_range(4000));
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Long output hold-off while input keeps coming, so the block backs up.
        if (p == 2 && i == 10) hold_req = 1'b1;
        // Input pause until every pending output has drained.
        if (p == 4 && i == 50) settle();
        offer_sample(pick_sample(), 1'b0, '0);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_out.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples and checked %0d outputs across %0d register writes.",
             samples_sent, outputs_checked, settings_written);
    $display("Mismatches found: %0d", mismatches);
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== audio_dynamic_range_compressor.f =====
rtl/adrc_pkg.sv
rtl/adrc_regs.sv
rtl/audio_dynamic_range_compressor.sv
bench/tb_audio_dynamic_range_compressor.sv
